@@ rtl/core/oal_pkg.sv @@
// Shared types and constants of the ordered array list core.
package oal_pkg;

  // Default list capacity.
  localparam int unsigned OAL_CAPACITY = 16;

  // Fixed field widths of the transfer payloads.
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FOUND_W  = 4;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 3'd0,
    KIND_APPEND   = 3'd1,
    KIND_ERASE_AT = 3'd2,
    KIND_ERASE_VAL = 3'd3,
    KIND_FIND     = 3'd4
  } oal_kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_POS   = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } oal_status_e;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic cap_hit;    // capture entry == value into the hit flag
    logic shift_hit;  // take the hit flag of the right neighbor
    logic ins;        // open a gap at the pivot and write the value there
    logic del;        // close the gap at the pivot
  } oal_cell_ctrl_t;

endpackage

@@ rtl/core/oal_if.sv @@
// Valid/ready channel interfaces for the request and result transfers.
interface oal_in_if;
  logic                                valid;
  logic                                ready;
  logic [oal_pkg::KIND_W-1:0]          kind;
  logic [oal_pkg::POS_W-1:0]           position;
  logic signed [oal_pkg::VALUE_W-1:0]  value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface oal_out_if;
  logic                           valid;
  logic                           ready;
  logic [oal_pkg::STATUS_W-1:0]   status;
  logic [oal_pkg::FOUND_W-1:0]    found_position;
  logic [oal_pkg::COUNT_W-1:0]    count_after;

  modport source (output valid, status, found_position, count_after, input ready);
  modport sink   (input valid, status, found_position, count_after, output ready);
endinterface

@@ rtl/core/oal_cell.sv @@
// One storage cell of the list row: an entry word and its search hit flag.
module oal_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                          clk_i,
  input  oal_pkg::oal_cell_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0]              pivot_i,
  input  logic [oal_pkg::VALUE_W-1:0]   value_i,
  input  logic [oal_pkg::VALUE_W-1:0]   left_entry_i,
  input  logic [oal_pkg::VALUE_W-1:0]   right_entry_i,
  input  logic                          right_hit_i,
  output logic [oal_pkg::VALUE_W-1:0]   entry_o,
  output logic                          hit_o
);
  import oal_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(INDEX);

  logic [VALUE_W-1:0] entry_d, entry_q;
  logic               hit_d, hit_q;

  // Move the entry: open a gap on insert, close it on erase
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (MyIdx == pivot_i) begin
        entry_d = value_i;
      end else if (MyIdx > pivot_i) begin
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.del) begin
      if (MyIdx >= pivot_i) begin
        entry_d = right_entry_i;
      end
    end
  end

  // Capture the compare result, then pass it down toward cell zero
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.cap_hit) begin
      hit_d = (entry_q == value_i);
    end else if (ctrl_i.shift_hit) begin
      hit_d = right_hit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

@@ rtl/core/ordered_array_list_core.sv @@
// Ordered array list: a row of CAPACITY entry cells under one controller.
//
// Usage: requests arrive on in_i (kind, position, value) and every request
// yields exactly one result on out_o (status, found_position, count_after).
// Both channels transfer when valid and ready are high at a rising clk_i.
// Insert, append and erase at a position move all cells in parallel: the
// result is registered and shows in the cycle after the request transfer.
// Find and erase by value search for the first match, or end at the last
// entry when there is none: every cell compares its entry in the accept
// cycle, then the hit flags step one cell per cycle toward cell zero while
// a counter tracks the position. An erase then closes the gap in the
// finishing cycle. One request is in work at a time; a new request is
// taken once the previous one has finished and its result is taken or
// being taken, so back-to-back insert, append and erase-at requests run
// at one per cycle while out_o.ready stays high.
// A stalled out_o.ready holds the result register and the list.
// Reset (rst_ni low) empties the list; entry words are not cleared.
module ordered_array_list_core #(
  parameter int unsigned CAPACITY = oal_pkg::OAL_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oal_in_if.sink      in_i,
  oal_out_if.source   out_o
);
  import oal_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e             state_d, state_q;
  logic [CNT_W-1:0]   cnt_d, cnt_q;
  logic [CNT_W-1:0]   scan_d, scan_q;
  logic               erase_d, erase_q;
  logic               out_valid_d, out_valid_q;
  logic [STATUS_W-1:0] status_d, status_q;
  logic [FOUND_W-1:0] found_d, found_q;
  logic [COUNT_W-1:0] count_d, count_q;

  oal_cell_ctrl_t     ctrl;
  logic [CNT_W-1:0]   pivot;
  logic               accept;
  logic               out_free;
  logic               full;
  logic               empty;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;

  logic [VALUE_W-1:0] entry_w [CAPACITY];
  logic               hit_w   [CAPACITY];

  // Handshake
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_i.valid && in_i.ready;

  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign pos_ext = CMP_W'(in_i.position);
  assign cnt_ext = CMP_W'(cnt_q);

  // Decode the request, drive the cell row and form the result
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    erase_d     = erase_q;
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    found_d     = found_q;
    count_d     = count_q;
    ctrl        = '0;
    pivot       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          status_d    = STAT_OK;
          found_d     = '0;
          unique case (oal_kind_e'(in_i.kind))
            KIND_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_d = STAT_BAD_POS;
              end else if (full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.ins = 1'b1;
                pivot    = CNT_W'(in_i.position);
                cnt_d    = cnt_q + CNT_W'(1);
              end
            end
            KIND_APPEND: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.ins = 1'b1;
                pivot    = cnt_q;
                cnt_d    = cnt_q + CNT_W'(1);
              end
            end
            KIND_ERASE_AT: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                status_d = STAT_BAD_POS;
              end else begin
                ctrl.del = 1'b1;
                pivot    = CNT_W'(in_i.position);
                cnt_d    = cnt_q - CNT_W'(1);
              end
            end
            KIND_ERASE_VAL, KIND_FIND: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                // Compare every cell now, walk the hit flags next
                out_valid_d  = 1'b0;
                ctrl.cap_hit = 1'b1;
                scan_d       = '0;
                erase_d      = (oal_kind_e'(in_i.kind) == KIND_ERASE_VAL);
                state_d      = ST_SCAN;
              end
            end
            default: begin
              // Unused codes leave the list alone
            end
          endcase
          count_d = COUNT_W'(cnt_d);
        end
      end

      ST_SCAN: begin
        if (out_free) begin
          if (hit_w[0]) begin
            out_valid_d = 1'b1;
            status_d    = STAT_OK;
            found_d     = FOUND_W'(scan_q);
            if (erase_q) begin
              ctrl.del = 1'b1;
              pivot    = scan_q;
              cnt_d    = cnt_q - CNT_W'(1);
            end
            count_d = COUNT_W'(cnt_d);
            state_d = ST_IDLE;
          end else if (scan_q == cnt_q - CNT_W'(1)) begin
            out_valid_d = 1'b1;
            status_d    = STAT_NOT_FOUND;
            found_d     = '0;
            count_d     = COUNT_W'(cnt_q);
            state_d     = ST_IDLE;
          end else begin
            // Advance the hit flags one cell toward the head
            ctrl.shift_hit = 1'b1;
            scan_d         = scan_q + CNT_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and the registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      erase_q     <= 1'b0;
      status_q    <= STAT_OK;
      found_q     <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      erase_q     <= erase_d;
      status_q    <= status_d;
      found_q     <= found_d;
      count_q     <= count_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.found_position = found_q;
  assign out_o.count_after    = count_q;

  // Row of entry cells, each linked to both neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_W-1:0] left_entry;
    logic [VALUE_W-1:0] right_entry;
    logic               right_hit;

    if (g == 0) begin : g_head
      assign left_entry = in_i.value;
    end else begin : g_mid_l
      assign left_entry = entry_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_entry = entry_w[g];
      assign right_hit   = 1'b0;
    end else begin : g_mid_r
      assign right_entry = entry_w[g+1];
      assign right_hit   = hit_w[g+1];
    end

    oal_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .pivot_i       (pivot),
      .value_i       (in_i.value),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .right_hit_i   (right_hit),
      .entry_o       (entry_w[g]),
      .hit_o         (hit_w[g])
    );
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the ordered array list core with a built-in list predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import oal_pkg::*;

  localparam int unsigned LIST_CAP      = OAL_CAPACITY;
  localparam int unsigned RANDOM_ITEMS  = 1925;
  localparam int unsigned LIMIT_CYCLES  = 1000000;
  localparam int unsigned HOLD_AT_A     = 1500;
  localparam int unsigned HOLD_AT_B     = 4000;
  localparam int unsigned HOLD_LEN      = 150;
  localparam int unsigned TAIL_CYCLES   = 24;

  // Codes above the last operation; the core must treat them as no-ops.
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_e;

  // One request; a drain marker makes the driver wait for every result.
  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
    logic                      drain;
  } request_t;

  typedef struct {
    oal_status_e        status;
    logic [FOUND_W-1:0] found;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  oal_in_if  req_if ();
  oal_out_if rsp_if ();

  ordered_array_list_core #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (rsp_if.source)
  );

  // Predicted list contents
  logic signed [VALUE_W-1:0] list_words [LIST_CAP];
  int                        list_len;

  request_t    request_backlog [$];
  outcome_t    pending_results [$];
  request_t    in_flight;

  int unsigned failures;
  int unsigned run_cycles;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned accepted;
  int unsigned results_seen;
  int unsigned kind_seen   [8];
  int unsigned status_seen [8];
  logic        rx_hold;
  logic        src_steady;
  logic        sink_steady;

  // Search values: a small pool makes matches and duplicates common.
  logic signed [VALUE_W-1:0] value_pool [8] = '{
    32'sd0, -32'sd1, 32'sd1, 32'h7fff_ffff, 32'h8000_0000, 32'sd5, -32'sd5, 32'sd42
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Close the gap at idx and shrink the list.
  function automatic void drop_entry(int idx);
    int i;
    for (i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
  endfunction

  // Apply one request to the predicted list and return its result.
  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int       i;
    int       hit;
    o.status = STAT_OK;
    o.found  = '0;
    case (r.kind)
      KIND_INSERT: begin
        if (int'(r.position) > list_len) begin
          o.status = STAT_BAD_POS;
        end else if (list_len >= LIST_CAP) begin
          o.status = STAT_FULL;
        end else begin
          for (i = list_len; i > int'(r.position); i--) list_words[i] = list_words[i - 1];
          list_words[r.position] = r.value;
          list_len++;
        end
      end
      KIND_APPEND: begin
        if (list_len >= LIST_CAP) begin
          o.status = STAT_FULL;
        end else begin
          list_words[list_len] = r.value;
          list_len++;
        end
      end
      KIND_ERASE_AT: begin
        if (list_len == 0) o.status = STAT_EMPTY;
        else if (int'(r.position) >= list_len) o.status = STAT_BAD_POS;
        else drop_entry(int'(r.position));
      end
      KIND_ERASE_VAL, KIND_FIND: begin
        if (list_len == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          hit = 0;
          while (hit < list_len && list_words[hit] != r.value) hit++;
          if (hit >= list_len) begin
            o.status = STAT_NOT_FOUND;
          end else begin
            o.found = FOUND_W'(hit);
            if (r.kind == KIND_ERASE_VAL) drop_entry(hit);
          end
        end
      end
      default: ;
    endcase
    o.count = COUNT_W'(list_len);
    return o;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(3, 1);
    return $urandom_range(48, 10);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  function automatic void push_req(logic [KIND_W-1:0] kind, logic [POS_W-1:0] position,
                                   logic signed [VALUE_W-1:0] value);
    request_t r;
    r.kind     = kind;
    r.position = position;
    r.value    = value;
    r.drain    = 1'b0;
    request_backlog.push_back(r);
  endfunction

  function automatic void push_drain();
    request_t r;
    r.kind     = KIND_FIND;
    r.position = '0;
    r.value    = '0;
    r.drain    = 1'b1;
    request_backlog.push_back(r);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 70) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return '0;
    if (roll < 55) return POS_W'($urandom_range(3));
    if (roll < 96) return POS_W'($urandom_range(LIST_CAP));
    return POS_W'($urandom_range(31, LIST_CAP + 1));
  endfunction

  // Drive requests from the backlog; predict each one at its transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    logic fire;
    logic offer;
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.kind     <= '0;
      req_if.position <= '0;
      req_if.value    <= '0;
      gap_left = 0;
    end else begin
      fire = req_if.valid && req_if.ready;
      if (fire) begin
        pending_results.push_back(apply_request(in_flight));
        accepted++;
        kind_seen[in_flight.kind]++;
        gap_left = (src_steady || $urandom_range(99) < 55) ? 0 : gap_len();
      end
      offer = req_if.valid && !fire;
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_backlog.size() > 0 && request_backlog[0].drain) begin
          if (pending_results.size() == 0) void'(request_backlog.pop_front());
        end else if (request_backlog.size() > 0) begin
          in_flight = request_backlog.pop_front();
          offer     = 1'b1;
        end
      end
      req_if.valid    <= offer;
      req_if.kind     <= in_flight.kind;
      req_if.position <= in_flight.position;
      req_if.value    <= in_flight.value;
    end
  end

  // Take results with random stalls and compare against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        status_seen[rsp_if.status]++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d found %0d count %0d",
                   $time, rsp_if.status, rsp_if.found_position, rsp_if.count_after);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_if.status));
          check_field("found_position", 32'(want.found), 32'(rsp_if.found_position));
          check_field("count_after", 32'(want.count), 32'(rsp_if.count_after));
        end
      end
      if (stall_left == 0 && !sink_steady && $urandom_range(99) < 20) stall_left = gap_len();
      rsp_if.ready <= (stall_left == 0) && !rx_hold;
      if (stall_left > 0) stall_left--;
    end
  end

  // Count cycles: long receiver hold-offs, steady stretches and the timeout.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold     <= 1'b0;
      src_steady  <= 1'b0;
      sink_steady <= 1'b0;
      hold_left = 0;
    end else begin
      run_cycles++;
      if (run_cycles == HOLD_AT_A || run_cycles == HOLD_AT_B) hold_left = HOLD_LEN;
      rx_hold <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
      if (run_cycles % 400 == 0) begin
        src_steady  <= ($urandom_range(3) == 0);
        sink_steady <= ($urandom_range(3) == 0);
      end
      if (run_cycles >= LIMIT_CYCLES) begin
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, run_cycles, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    phase_e            phase;
    int unsigned       made;
    int unsigned       span;
    int unsigned       roll;
    int                j;
    logic [KIND_W-1:0] kind;

    list_len        = 0;

    // Directed: empty-list failures, both ends of the list, spare codes.
    push_req(KIND_ERASE_AT, 5'd0, 32'sd0);
    push_req(KIND_ERASE_VAL, 5'd0, 32'sd0);
    push_req(KIND_FIND, 5'd0, 32'sd0);
    push_req(KIND_INSERT, 5'd1, 32'sd9);
    push_req(KIND_INSERT, 5'd0, 32'h7fff_ffff);
    push_req(KIND_APPEND, 5'd0, 32'h8000_0000);
    push_req(KIND_INSERT, 5'd2, 32'sd0);
    push_req(KIND_INSERT, 5'd1, -32'sd1);
    push_req(KIND_FIND, 5'd0, 32'h8000_0000);
    push_req(KIND_FIND, 5'd0, 32'sd12345);
    push_req(KIND_ERASE_AT, 5'd4, 32'sd0);
    push_req(KIND_ERASE_VAL, 5'd0, 32'h7fff_ffff);
    push_req(KIND_SPARE_FIRST, 5'd31, 32'h7fff_ffff);
    push_req(KIND_SPARE_LAST, 5'd16, 32'h8000_0000);
    // Fill to capacity, then knock on the full list.
    for (j = 3; j < LIST_CAP; j++) begin
      push_req(KIND_APPEND, 5'd0, (j % 2 == 0) ? (32'h5555_5555 ^ j) : (32'haaaa_aaaa ^ j));
    end
    push_req(KIND_APPEND, 5'd0, 32'sd7);
    push_req(KIND_INSERT, 5'd16, 32'sd7);
    push_req(KIND_INSERT, 5'd17, 32'sd7);
    push_req(KIND_FIND, 5'd0, 32'haaaa_aaaa ^ (LIST_CAP - 1));
    push_req(KIND_ERASE_AT, 5'd15, 32'sd0);
    push_req(KIND_ERASE_AT, 5'd0, 32'sd0);
    push_drain();

    // Random: phases that grow, shrink or churn the list.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase = phase_e'($urandom_range(2));
      span  = $urandom_range(60, 15);
      repeat (span) begin
        roll = $urandom_range(99);
        case (phase)
          PH_GROW: kind = (roll < 45) ? KIND_INSERT : (roll < 80) ? KIND_APPEND :
                          (roll < 88) ? KIND_ERASE_AT : (roll < 94) ? KIND_ERASE_VAL : KIND_FIND;
          PH_SHRINK: kind = (roll < 10) ? KIND_INSERT : (roll < 18) ? KIND_APPEND :
                            (roll < 55) ? KIND_ERASE_AT : (roll < 80) ? KIND_ERASE_VAL :
                            KIND_FIND;
          default: kind = KIND_W'($urandom_range(KIND_FIND, KIND_INSERT));
        endcase
        if ($urandom_range(99) < 2) begin
          kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
        end else begin
          made++;
        end
        push_req(kind, pick_position(), pick_value());
      end
      if ($urandom_range(99) < 4) push_drain();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every request is in and every result is back.
    while (request_backlog.size() > 0 || req_if.valid || pending_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: insert %0d, append %0d, erase at %0d, erase value %0d, find %0d",
             accepted, kind_seen[KIND_INSERT], kind_seen[KIND_APPEND],
             kind_seen[KIND_ERASE_AT], kind_seen[KIND_ERASE_VAL], kind_seen[KIND_FIND]);
    $display("Results %0d: ok %0d, bad position %0d, full %0d, empty %0d, not found %0d",
             results_seen, status_seen[STAT_OK], status_seen[STAT_BAD_POS],
             status_seen[STAT_FULL], status_seen[STAT_EMPTY], status_seen[STAT_NOT_FOUND]);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/oal_pkg.sv
rtl/core/oal_if.sv
rtl/core/oal_cell.sv
rtl/core/ordered_array_list_core.sv
tb/tb_top.sv
